>>> rtl/lru_pr_pkg.sv
// Shared constants and types for the LRU page replacement block.
package lru_pr_pkg;

    localparam int MAX_FRAMES_DEF = 8;
    localparam int PAGE_BITS_DEF  = 8;

    localparam int CFG_W   = 4;
    localparam int FRAME_W = 3;
    localparam int FAULT_W = 16;

    localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
    localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame_index;
        logic               evicted_valid;
        logic [FAULT_W-1:0] fault_total;
    } status_t;

endpackage

>>> rtl/lru_page_replacement_top.sv
// LRU page replacement block: handshake, configuration register and result register.
// One page reference is accepted per clock cycle while the output is not stalled: the
// reference is captured in an input register, the tag compare, victim choice and rank
// update over all frames are computed together against that register, and the result
// is held in an output register until taken. The frame table updates as each result is
// registered, so back-to-back references see each other's effect. The user writes
// frames_in_use through cfg_we/cfg_wdata only while no item is in flight; the block
// does not enforce it. Zero acts as one frame and values above MAX_FRAMES as MAX_FRAMES.
module lru_page_replacement_top #(
    parameter int MAX_FRAMES = lru_pr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = lru_pr_pkg::PAGE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [lru_pr_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [PAGE_BITS-1:0]           s_page_number,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_hit,
    output logic [lru_pr_pkg::FRAME_W-1:0] m_frame_index,
    output logic                           m_evicted_valid,
    output logic [PAGE_BITS-1:0]           m_evicted_page,
    output logic [lru_pr_pkg::FAULT_W-1:0] m_fault_total
);
    import lru_pr_pkg::*;

    logic [CFG_W-1:0]     cfg_reg;
    logic                 in_valid_reg, in_valid_next;
    logic [PAGE_BITS-1:0] in_page_reg;
    logic                 out_valid_reg, out_valid_next;
    status_t              status_reg;
    logic [PAGE_BITS-1:0] evicted_page_reg;
    status_t              status;
    logic [PAGE_BITS-1:0] evicted_page;
    logic                 advance, proc_en, in_take;

    assign advance = !out_valid_reg || m_ready;
    assign proc_en = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;

    assign in_valid_next  = in_take ? 1'b1 : (proc_en ? 1'b0 : in_valid_reg);
    assign out_valid_next = proc_en ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    lru_pr_core #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .proc_en       (proc_en),
        .page_in       (in_page_reg),
        .frames_in_use (cfg_reg),
        .status        (status),
        .evicted_page  (evicted_page)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg       <= CFG_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                cfg_reg <= cfg_wdata;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_page_reg <= s_page_number;
        end
        if (proc_en) begin
            status_reg       <= status;
            evicted_page_reg <= evicted_page;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_hit           = status_reg.hit;
    assign m_frame_index   = status_reg.frame_index;
    assign m_evicted_valid = status_reg.evicted_valid;
    assign m_evicted_page  = evicted_page_reg;
    assign m_fault_total   = status_reg.fault_total;

endmodule

>>> rtl/lru_pr_core.sv
// Frame table, recency ranks and fault counter with the combinational lookup and registered update.
module lru_pr_core #(
    parameter int MAX_FRAMES = lru_pr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = lru_pr_pkg::PAGE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         proc_en,
    input  logic [PAGE_BITS-1:0]         page_in,
    input  logic [lru_pr_pkg::CFG_W-1:0] frames_in_use,
    output lru_pr_pkg::status_t          status,
    output logic [PAGE_BITS-1:0]         evicted_page
);
    import lru_pr_pkg::*;

    localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int OLD_W  = RANK_W + 1;
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_FRAMES - 1);
    localparam logic [OLD_W-1:0]  OLD_MISS = OLD_W'(MAX_FRAMES);

    logic [PAGE_BITS-1:0] page_reg  [MAX_FRAMES];
    logic [RANK_W-1:0]    rank_reg  [MAX_FRAMES];
    logic [RANK_W-1:0]    rank_next [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] valid_reg, valid_next;
    logic [FAULT_W-1:0]   fault_reg, fault_next, fault_upd;

    logic [MAX_FRAMES-1:0] active, match, empty;
    logic                 hit, has_empty, miss;
    logic [IDX_W-1:0]     hit_idx, empty_idx, vic_idx, tgt;
    logic [RANK_W-1:0]    best;
    logic [OLD_W-1:0]     old_rank;

    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            active[i] = (i == 0) || (i < int'(frames_in_use));
            match[i]  = active[i] && valid_reg[i] && (page_reg[i] == page_in);
            empty[i]  = active[i] && !valid_reg[i];
        end
    end

    always_comb begin
        hit_idx   = '0;
        empty_idx = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = IDX_W'(i);
            end
            if (empty[i]) begin
                empty_idx = IDX_W'(i);
            end
        end
    end

    // Largest rank wins; strict compare keeps the lowest index among ties.
    always_comb begin
        best    = '0;
        vic_idx = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (active[i] && (rank_reg[i] > best)) begin
                best    = rank_reg[i];
                vic_idx = IDX_W'(i);
            end
        end
    end

    assign hit       = |match;
    assign has_empty = |empty;
    assign miss      = !hit;
    assign tgt       = hit ? hit_idx : (has_empty ? empty_idx : vic_idx);
    assign old_rank  = hit ? {1'b0, rank_reg[hit_idx]} : OLD_MISS;
    assign fault_upd = (miss && (fault_reg != FAULT_MAX)) ? fault_reg + 1'b1 : fault_reg;

    always_comb begin
        valid_next = valid_reg;
        fault_next = fault_reg;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            rank_next[i] = rank_reg[i];
        end
        if (proc_en) begin
            fault_next = fault_upd;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                if (IDX_W'(i) == tgt) begin
                    rank_next[i] = '0;
                end else if (active[i] && valid_reg[i] &&
                             ({1'b0, rank_reg[i]} < old_rank) && (rank_reg[i] < RANK_MAX)) begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
            if (miss) begin
                valid_next[tgt] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            fault_reg <= '0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            fault_reg <= fault_next;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_en && miss) begin
            page_reg[tgt] <= page_in;
        end
    end

    assign status.hit           = hit;
    assign status.frame_index   = FRAME_W'(tgt);
    assign status.evicted_valid = miss && !has_empty;
    assign status.fault_total   = fault_upd;
    assign evicted_page         = (miss && !has_empty) ? page_reg[vic_idx] : '0;

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_en && hit |-> !status.evicted_valid)
        else $error("eviction reported on a hit");

    a_evict_full: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_en && status.evicted_valid |-> ((valid_reg & active) == active))
        else $error("eviction while an active frame is empty");

    a_target_recent: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_en |=> valid_reg[$past(tgt)] && (rank_reg[$past(tgt)] == '0))
        else $error("target frame not valid and most recent after update");

    a_fault_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> fault_reg >= $past(fault_reg))
        else $error("fault counter decreased");

endmodule

>>> bench/lru_page_replacement_top_test.sv
// Self-checking testbench for the LRU page replacement block with a built-in frame table predictor.
module lru_page_replacement_top_test;
    import lru_pr_pkg::*;

    localparam int FRAMES = MAX_FRAMES_DEF;
    localparam int PAGE_W = PAGE_BITS_DEF;

    typedef struct packed {
        status_t           status;
        logic [PAGE_W-1:0] evicted_page;
    } page_result_t;

    typedef enum logic {ROW_REF, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic         pinned;
        page_result_t want;
    } pin_t;

    typedef struct packed {
        row_kind_t    kind;
        logic [7:0]   value;
        pin_t         pin;
    } stim_row_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [CFG_W-1:0]    cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic [PAGE_W-1:0]   s_page_number;
    logic                m_valid;
    logic                m_ready;
    logic                m_hit;
    logic [FRAME_W-1:0]  m_frame_index;
    logic                m_evicted_valid;
    logic [PAGE_W-1:0]   m_evicted_page;
    logic [FAULT_W-1:0]  m_fault_total;

    logic [PAGE_W-1:0]   held_page [FRAMES];
    logic                held [FRAMES];
    logic [FRAME_W-1:0]  age [FRAMES];
    logic [FAULT_W-1:0]  faults;
    logic [CFG_W-1:0]    frame_setting;

    page_result_t        pending_results [$];
    pin_t                pinned_outcomes [$];
    int                  refs_sent;
    int                  results_taken;
    int                  hit_count;
    int                  evict_count;
    int                  mismatches;
    int                  setting_writes;
    int                  send_max;
    int                  recv_max;
    int                  recv_hold;

    logic [CFG_W-1:0]    phase_setting [12] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd9,
                                                4'd5, 4'd2, 4'd7, 4'd4, 4'd6, 4'd8};

    lru_page_replacement_top #(
        .MAX_FRAMES(FRAMES),
        .PAGE_BITS (PAGE_W)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_page_number  (s_page_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_frame_index  (m_frame_index),
        .m_evicted_valid(m_evicted_valid),
        .m_evicted_page (m_evicted_page),
        .m_fault_total  (m_fault_total)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("lru_page_replacement_top test failed");
        $finish;
    end

    function automatic int active_frames(input logic [CFG_W-1:0] setting);
        if (setting == 0) return 1;
        if (setting > FRAMES) return FRAMES;
        return int'(setting);
    endfunction

    function automatic void promote_frame(input int slot, input int n, input int old_age);
        for (int i = 0; i < n; i++) begin
            if (i != slot && held[i] && age[i] < old_age && age[i] < FRAMES - 1) begin
                age[i] = age[i] + 1'b1;
            end
        end
        age[slot] = '0;
    endfunction

    function automatic page_result_t predict_reference(input logic [PAGE_W-1:0] page);
        page_result_t r;
        int n;
        int slot;
        int oldest;
        bit found;
        bit empty;
        r = '0;
        n = active_frames(frame_setting);
        slot = 0;
        found = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (!found && held[i] && held_page[i] == page) begin
                slot = i;
                found = 1'b1;
            end
        end
        if (found) begin
            r.status.hit = 1'b1;
            promote_frame(slot, n, int'(age[slot]));
        end else begin
            empty = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (!empty && !held[i]) begin
                    slot = i;
                    empty = 1'b1;
                end
            end
            if (!empty) begin
                oldest = 0;
                slot = 0;
                for (int i = 0; i < n; i++) begin
                    if (age[i] > oldest) begin
                        oldest = int'(age[i]);
                        slot = i;
                    end
                end
                r.status.evicted_valid = 1'b1;
                r.evicted_page = held_page[slot];
            end
            held_page[slot] = page;
            held[slot] = 1'b1;
            promote_frame(slot, n, FRAMES);
            if (faults != FAULT_MAX) faults = faults + 1'b1;
        end
        r.status.frame_index = slot[FRAME_W-1:0];
        r.status.fault_total = faults;
        return r;
    endfunction

    function automatic stim_row_t stim_row(input row_kind_t kind, input int value,
                                           input bit pinned, input bit hit, input int frame,
                                           input bit ev, input int ev_page, input int total);
        stim_row_t r;
        r = '0;
        r.kind = kind;
        r.value = value[7:0];
        r.pin.pinned = pinned;
        r.pin.want.status.hit = hit;
        r.pin.want.status.frame_index = frame[FRAME_W-1:0];
        r.pin.want.status.evicted_valid = ev;
        r.pin.want.evicted_page = ev_page[PAGE_W-1:0];
        r.pin.want.status.fault_total = total[FAULT_W-1:0];
        return r;
    endfunction

    task automatic send_reference(input logic [PAGE_W-1:0] page, input int gap, input pin_t pin);
        pinned_outcomes = {pinned_outcomes, pin};
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_page_number <= page;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        refs_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (results_taken < refs_sent) @(posedge aclk);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_wdata <= value;
        cfg_we <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        frame_setting = value;
        setting_writes++;
    endtask

    always @(posedge aclk) begin : result_check
        page_result_t want;
        pin_t pin;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_taken++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $error("Result arrived with no reference pending (frame %0d).",
                           m_frame_index);
                end else begin
                    want = pending_results.pop_front();
                    if (m_hit !== want.status.hit) begin
                        mismatches++;
                        $error("hit: expected %0d, got %0d", want.status.hit, m_hit);
                    end
                    if (m_frame_index !== want.status.frame_index) begin
                        mismatches++;
                        $error("frame_index: expected %0d, got %0d",
                               want.status.frame_index, m_frame_index);
                    end
                    if (m_evicted_valid !== want.status.evicted_valid) begin
                        mismatches++;
                        $error("evicted_valid: expected %0d, got %0d",
                               want.status.evicted_valid, m_evicted_valid);
                    end
                    if (m_evicted_page !== want.evicted_page) begin
                        mismatches++;
                        $error("evicted_page: expected %0d, got %0d",
                               want.evicted_page, m_evicted_page);
                    end
                    if (m_fault_total !== want.status.fault_total) begin
                        mismatches++;
                        $error("fault_total: expected %0d, got %0d",
                               want.status.fault_total, m_fault_total);
                    end
                    if (want.status.hit) hit_count++;
                    if (want.status.evicted_valid) evict_count++;
                end
            end
            if (s_valid && s_ready) begin
                want = predict_reference(s_page_number);
                pin = pinned_outcomes.pop_front();
                if (pin.pinned) want = pin.want;
                pending_results = {pending_results, want};
            end
        end
    end

    initial begin
        m_ready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin : receiver
            int stall;
            if (recv_hold > 0) begin
                stall = recv_hold;
                recv_hold = 0;
            end else begin
                stall = $urandom_range(0, recv_max);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin
        stim_row_t directed [$];
        logic [PAGE_W-1:0] page;
        logic [PAGE_W-1:0] last_page;
        logic [CFG_W-1:0] setting;
        int n;
        int base;
        int span;
        int burst;
        int gap;
        int choice;

        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_page_number <= '0;
        for (int i = 0; i < FRAMES; i++) begin
            held_page[i] = '0;
            held[i] = 1'b0;
            age[i] = '0;
        end
        faults = '0;
        frame_setting = CFG_RESET;
        refs_sent = 0;
        results_taken = 0;
        hit_count = 0;
        evict_count = 0;
        mismatches = 0;
        setting_writes = 0;
        recv_hold = 0;
        recv_max = 17;
        send_max = 17;
        last_page = '0;
        burst = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Page zero must miss after reset even though the predictor's empty frames hold page zero.
        directed = {directed, stim_row(ROW_REF, 0,   1, 0, 0, 0, 0,   1)};
        directed = {directed, stim_row(ROW_REF, 255, 1, 0, 1, 0, 0,   2)};
        directed = {directed, stim_row(ROW_REF, 0,   1, 1, 0, 0, 0,   2)};
        directed = {directed, stim_row(ROW_REF, 170, 1, 0, 2, 0, 0,   3)};
        directed = {directed, stim_row(ROW_REF, 85,  1, 0, 3, 0, 0,   4)};
        directed = {directed, stim_row(ROW_REF, 1,   1, 0, 4, 0, 0,   5)};
        directed = {directed, stim_row(ROW_REF, 2,   1, 0, 5, 0, 0,   6)};
        directed = {directed, stim_row(ROW_REF, 3,   1, 0, 6, 0, 0,   7)};
        directed = {directed, stim_row(ROW_REF, 4,   1, 0, 7, 0, 0,   8)};
        directed = {directed, stim_row(ROW_REF, 200, 1, 0, 1, 1, 255, 9)};
        directed = {directed, stim_row(ROW_REF, 0,   1, 1, 0, 0, 0,   9)};
        // Shrink the table so that a page held only in an inactive frame misses.
        directed = {directed, stim_row(ROW_CFG, 2,   0, 0, 0, 0, 0,   0)};
        directed = {directed, stim_row(ROW_REF, 3,   0, 0, 0, 0, 0,   0)};
        directed = {directed, stim_row(ROW_CFG, 0,   0, 0, 0, 0, 0,   0)};
        directed = {directed, stim_row(ROW_REF, 0,   0, 0, 0, 0, 0,   0)};
        directed = {directed, stim_row(ROW_REF, 9,   0, 0, 0, 0, 0,   0)};
        // Growing again brings back stale frames, duplicate pages and tied ranks.
        directed = {directed, stim_row(ROW_CFG, 15,  0, 0, 0, 0, 0,   0)};
        directed = {directed, stim_row(ROW_REF, 3,   0, 0, 0, 0, 0,   0)};
        directed = {directed, stim_row(ROW_REF, 77,  0, 0, 0, 0, 0,   0)};
        directed = {directed, stim_row(ROW_REF, 78,  0, 0, 0, 0, 0,   0)};
        directed = {directed, stim_row(ROW_REF, 128, 0, 0, 0, 0, 0,   0)};
        directed = {directed, stim_row(ROW_REF, 127, 0, 0, 0, 0, 0,   0)};
        directed = {directed, stim_row(ROW_CFG, 8,   0, 0, 0, 0, 0,   0)};
        directed = {directed, stim_row(ROW_REF, 255, 0, 0, 0, 0, 0,   0)};

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG) begin
                write_frames(directed[i].value[CFG_W-1:0]);
            end else begin
                send_reference(directed[i].value, $urandom_range(0, 17), directed[i].pin);
            end
        end

        for (int phase = 0; phase < 12; phase++) begin
            setting = (phase >= 10) ? 4'($urandom_range(0, 15)) : phase_setting[phase];
            write_frames(setting);
            n = active_frames(setting);
            choice = $urandom_range(0, 2);
            send_max = (phase == 0) ? 0 : (choice == 0) ? 0 : (choice == 1) ? 3 : 17;
            choice = $urandom_range(0, 2);
            recv_max = (phase == 0) ? 0 : (choice == 0) ? 0 : (choice == 1) ? 3 : 17;
            base = $urandom_range(0, 255);
            span = n + $urandom_range(0, 4);
            for (int k = 0; k < 160; k++) begin
                // The receiver stops for a long stretch while references keep coming.
                if (phase == 1 && k == 40) begin
                    recv_hold = 90;
                    burst = 40;
                end
                if (burst > 0) begin
                    gap = 0;
                    burst--;
                end else begin
                    gap = $urandom_range(0, send_max);
                end
                choice = $urandom_range(0, 9);
                if (choice < 7) page = PAGE_W'((base + $urandom_range(0, span)) % 256);
                else if (choice < 9) page = PAGE_W'($urandom_range(0, 255));
                else page = last_page;
                last_page = page;
                send_reference(page, gap, '0);
            end
        end

        write_frames(4'd8);
        recv_max = 17;
        for (int k = 0; k < 40; k++) begin
            send_reference(PAGE_W'($urandom_range(16, 27)), $urandom_range(0, 17), '0);
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (pending_results.size() != 0) begin
            mismatches++;
            $error("%0d expected results never arrived.", pending_results.size());
        end

        $display("Checked %0d page references: %0d hits and %0d evictions.",
                 results_taken, hit_count, evict_count);
        $display("Frame count was written %0d times; the fault counter ended at %0d.",
                 setting_writes, faults);
        if (mismatches == 0) begin
            $display("lru_page_replacement_top test passed");
        end else begin
            $display("lru_page_replacement_top test failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/lru_pr_pkg.sv
rtl/lru_pr_core.sv
rtl/lru_page_replacement_top.sv
bench/lru_page_replacement_top_test.sv
